// ----- design/srrg_pkg.sv -----
// Shared constants and types of the seeded range random generator.
// No dependencies; imported by the serial multiplier, the serial divider and the top level.
`default_nettype none

package srrg_pkg;

    localparam int unsigned STATE_W = 64;
    localparam int unsigned BOUND_W = 32;
    localparam int unsigned SPAN_W  = BOUND_W + 1;
    localparam int unsigned CNT_W   = $clog2(STATE_W);

    localparam logic [STATE_W-1:0] LCG_MUL = 64'd6364136223846793005;
    localparam logic [STATE_W-1:0] LCG_ADD = 64'd1442695040888963407;
    localparam logic [STATE_W-1:0] OUT_MUL = 64'd2685821657736338717;

    localparam int unsigned SH_A = 12;
    localparam int unsigned SH_B = 25;
    localparam int unsigned SH_C = 27;

    // Status of a serial arithmetic unit as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

`default_nettype wire

// ----- design/srrg_mul.sv -----
// Bit-serial 64x64 multiplier, product kept modulo 2^64, one multiplier bit per cycle.
// Depends on srrg_pkg.
`default_nettype none

module srrg_mul
    import srrg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [STATE_W-1:0] i_mcand,
    input  wire logic [STATE_W-1:0] i_mplr,
    output t_unit_stat              o_stat,
    output logic      [STATE_W-1:0] o_prod
);

    logic [STATE_W-1:0] r_mcand;
    logic [STATE_W-1:0] r_mplr;
    logic [STATE_W-1:0] r_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STATE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The multiplicand moves left and the multiplier right, so the adder stays fixed.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_mplr  <= i_mplr;
            r_acc   <= '0;
        end else if (r_busy) begin
            r_mcand <= {r_mcand[STATE_W-2:0], 1'b0};
            r_mplr  <= {1'b0, r_mplr[STATE_W-1:1]};
            if (r_mplr[0]) begin
                r_acc <= r_acc + r_mcand;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = r_acc;

endmodule

`default_nettype wire

// ----- design/srrg_div.sv -----
// Restoring remainder unit: 64-bit dividend modulo a 33-bit divisor, one quotient bit per cycle.
// Depends on srrg_pkg.
`default_nettype none

module srrg_div
    import srrg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [STATE_W-1:0] i_dividend,
    input  wire logic [SPAN_W-1:0]  i_divisor,
    output t_unit_stat              o_stat,
    output logic      [BOUND_W-1:0] o_rem
);

    logic [STATE_W-1:0] r_dvd;
    logic [SPAN_W-1:0]  r_dvs;
    logic [BOUND_W-1:0] r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [SPAN_W-1:0]  trial;
    logic [SPAN_W-1:0]  diff;

    // The partial remainder stays below the divisor, which is at most 2^32,
    // so it always fits in 32 bits.
    always_comb begin
        trial = {r_rem, r_dvd[STATE_W-1]};
        diff  = trial - r_dvs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STATE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[STATE_W-2:0], 1'b0};
            if (trial >= r_dvs) begin
                r_rem <= diff[BOUND_W-1:0];
            end else begin
                r_rem <= trial[BOUND_W-1:0];
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule

`default_nettype wire

// ----- design/seeded_range_random_generator.sv -----
// Seeded range random generator: xorshift64* source reduced into a signed inclusive range.
// Each request passes the range check and xorshift step, the bit-serial multiply, the bit-serial reduction
// and the hand-over to the output register; an inverted range skips the multiply and the reduction.
// A new request is taken only after the last one is handed over; a full, unread output register holds it back.
// A seed write holds both inputs not ready while the LCG step runs on the multiplier.
// Reset (synchronous, active low) loads the state with the LCG step of seed 0 at once.
`default_nettype none

module seeded_range_random_generator
    import srrg_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Seed write channel.
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [STATE_W-1:0]   i_cfg_data,
    // Request stream.
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [2*BOUND_W-1:0] s_axis_tdata,  // range_low [31:0], range_high [63:32]
    // Result stream.
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [BOUND_W-1:0]        m_axis_tdata,  // value [31:0]
    output logic [0:0]                m_axis_tuser   // range_error [0]
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a request or a seed write
    localparam logic [2:0] ST_SEED = 3'd1;  // LCG step of a new seed on the multiplier
    localparam logic [2:0] ST_XS   = 3'd2;  // range check, xorshift step, span
    localparam logic [2:0] ST_MUL  = 3'd3;  // output scrambling multiply
    localparam logic [2:0] ST_DIV  = 3'd4;  // reduction modulo the span
    localparam logic [2:0] ST_FIN  = 3'd5;  // hand the result to the output register

    logic [2:0]         r_state;
    logic [STATE_W-1:0] r_gen;
    logic [BOUND_W-1:0] r_lo;
    logic [BOUND_W-1:0] r_hi;
    logic [SPAN_W-1:0]  r_span;
    logic [BOUND_W-1:0] r_val;
    logic               r_err;
    logic               r_out_valid;
    logic [BOUND_W-1:0] r_out_val;
    logic               r_out_err;

    logic               cfg_fire;
    logic               in_fire;
    logic               out_fire;
    logic               inverted;
    logic [STATE_W-1:0] xs1;
    logic [STATE_W-1:0] xs2;
    logic [STATE_W-1:0] xs3;
    logic [SPAN_W-1:0]  span;
    logic               mul_start;
    logic [STATE_W-1:0] mul_a;
    logic [STATE_W-1:0] mul_b;
    logic               div_start;
    t_unit_stat         mul_stat;
    t_unit_stat         div_stat;
    logic [STATE_W-1:0] mul_prod;
    logic [BOUND_W-1:0] div_rem;

    assign o_cfg_ready   = (r_state == ST_IDLE);
    // A seed write wins if both arrive in the same idle cycle; the request waits.
    assign s_axis_tready = (r_state == ST_IDLE) & ~i_cfg_valid;
    assign cfg_fire      = i_cfg_valid & o_cfg_ready;
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign out_fire      = r_out_valid & m_axis_tready;

    // Range check and the xorshift (12, 25, 27) step of the current state.
    always_comb begin
        inverted = $signed(r_hi) < $signed(r_lo);
        xs1      = r_gen ^ (r_gen >> SH_A);
        xs2      = xs1 ^ (xs1 << SH_B);
        xs3      = xs2 ^ (xs2 >> SH_C);
        // With high not below low the difference is in [0, 2^32 - 1], so 33 bits hold span.
        span     = {r_hi[BOUND_W-1], r_hi} - {r_lo[BOUND_W-1], r_lo} + SPAN_W'(1);
    end

    // The multiplier is shared by the seed LCG step and the output scrambling.
    always_comb begin
        mul_start = cfg_fire || ((r_state == ST_XS) && !inverted);
        mul_a     = (r_state == ST_IDLE) ? i_cfg_data : xs3;
        mul_b     = (r_state == ST_IDLE) ? LCG_MUL : OUT_MUL;
        div_start = (r_state == ST_MUL) && mul_stat.done;
    end

    srrg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_mcand (mul_a),
        .i_mplr  (mul_b),
        .o_stat  (mul_stat),
        .o_prod  (mul_prod)
    );

    srrg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mul_prod),
        .i_divisor  (r_span),
        .o_stat     (div_stat),
        .o_rem      (div_rem)
    );

    // Sequencer and generator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_gen   <= LCG_ADD;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (cfg_fire) begin
                        r_state <= ST_SEED;
                    end else if (in_fire) begin
                        r_state <= ST_XS;
                    end
                end
                ST_SEED: begin
                    if (mul_stat.done) begin
                        r_gen   <= mul_prod + LCG_ADD;
                        r_state <= ST_IDLE;
                    end
                end
                ST_XS: begin
                    // An inverted range leaves the state untouched and skips the arithmetic.
                    if (inverted) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_gen   <= xs3;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (mul_stat.done) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Request payload and the result under construction.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_lo <= s_axis_tdata[BOUND_W-1:0];
            r_hi <= s_axis_tdata[2*BOUND_W-1:BOUND_W];
        end
        if (r_state == ST_XS) begin
            r_span <= span;
            r_val  <= r_lo;
            r_err  <= inverted;
        end
        if ((r_state == ST_DIV) && div_stat.done) begin
            r_val <= r_lo + div_rem;
        end
    end

    // Output register: holds a finished result while the next request is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FIN) && (!r_out_valid || m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && (!r_out_valid || m_axis_tready)) begin
            r_out_val <= r_val;
            r_out_err <= r_err;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_val;
    assign m_axis_tuser[0] = r_out_err;

    // An accepted request always goes to the range check next.
    a_accept_to_xs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_XS))
        else $error("accepted request did not reach the range check");

    // The multiplier only finishes while the sequencer waits for it.
    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_stat.done |-> ((r_state == ST_SEED) || (r_state == ST_MUL)))
        else $error("multiplier finished outside a multiply state");

    // The divider runs only during the reduction.
    a_div_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> (r_state == ST_DIV))
        else $error("divider busy outside the reduction state");

    // A new result beat appears only when the sequencer hands one over.
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_FIN))
        else $error("result beat raised without a finished item");

    // An error result never advances the generator state.
    a_err_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_XS) && inverted) |=> $stable(r_gen))
        else $error("inverted range changed the generator state");

endmodule

`default_nettype wire
